// ----- hw/rtl/backslash_escape_decoder_macros.svh -----
// ---------------------------------------------------------------------------
// backslash escape decoder assertion macros
// shared concurrent assertion forms, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef BACKSLASH_ESCAPE_DECODER_MACROS_SVH
`define BACKSLASH_ESCAPE_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define BED_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define BED_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BED_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/bed_pkg.sv -----
// ---------------------------------------------------------------------------
// bed_pkg
// types and character constants of the backslash escape decoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bed_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned OVAL_W  = 9;
    localparam int unsigned GROUP_N = 3;

    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_UC_N      = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_ZERO      = 8'h30;
    localparam logic [BYTE_W-1:0] CH_SEVEN     = 8'h37;
    localparam logic [BYTE_W-1:0] CH_LC_T      = 8'h74;
    localparam logic [BYTE_W-1:0] CH_LC_S      = 8'h73;
    localparam logic [BYTE_W-1:0] CH_LC_N      = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_LC_R      = 8'h72;
    localparam logic [BYTE_W-1:0] CH_LC_B      = 8'h62;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CH_BLANK     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;

    // escape phase, one-hot
    typedef enum logic [3:0] {
        PH_PLAIN = 4'b0001,
        PH_ESC   = 4'b0010,
        PH_OCT1  = 4'b0100,
        PH_OCT2  = 4'b1000
    } t_phase;

    // results of one input transaction
    typedef struct packed {
        logic [GROUP_N-1:0][BYTE_W-1:0] bytes;
        logic [1:0]                     cnt;
        logic                           bare;
        logic                           arg_last;
    } t_group;

endpackage

`default_nettype wire

// ----- hw/rtl/backslash_escape_decoder.sv -----
// ---------------------------------------------------------------------------
// backslash_escape_decoder
// streaming decoder of backslash escapes in argument strings
// ---------------------------------------------------------------------------
// usage:
//   input stream: one argument character per transaction in s_axis_tdata,
//   s_axis_tlast set on the final character of the argument
//   output stream: one decoded character per transaction; tuser bit 0 says
//   whether tdata carries a character (clear on a bare end-of-argument mark),
//   tuser bit 1 marks the last result of an input transaction, tlast marks
//   the last result of the argument
//   each input byte yields zero to three results (octal escapes, a zero octal
//   value becoming backslash N, unknown escapes passed on with their backslash)
// decode: each accepted byte is decoded combinationally into the buffer;
//   one byte is decoded per cycle in a single pass while the buffer has room
// throughput: one input per cycle while each input yields at most one result
//   and the receiver is ready; a byte with k results sends them one by one
// stall: a two-group result buffer lets input continue for one more
//   transaction while the receiver stalls; s_axis_tready drops when it is full
// reset: the escape phase returns to plain text and the buffer empties
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module backslash_escape_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // arg_last
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]       m_axis_tuser,   // [0] byte_valid, [1] run_last
    output logic             m_axis_tlast    // arg_end
);
    import bed_pkg::*;

    logic    w_accept;
    logic    w_push;
    logic    w_bare;
    t_group  w_group;

    // input transaction taken when the buffer has a free group slot
    assign w_accept = s_axis_tvalid && s_axis_tready;

    bed_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_group  (w_group)
    );

    // bytes that produce nothing (opening backslash, pending octal digits)
    // never enter the buffer
    assign w_push = w_accept && (w_group.cnt != 2'd0);

    bed_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_group    (w_group),
        .o_ready    (s_axis_tready),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_byte     (m_axis_tdata),
        .o_bare     (w_bare),
        .o_arg_end  (m_axis_tlast),
        .o_run_last (m_axis_tuser[1])
    );

    assign m_axis_tuser[0] = ~w_bare;

endmodule

`default_nettype wire

// ----- hw/rtl/bed_decode.sv -----
// ---------------------------------------------------------------------------
// bed_decode
// escape phase state and combinational decode of one input byte
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "backslash_escape_decoder_macros.svh"

module bed_decode (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire logic [bed_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                     i_last,
    output bed_pkg::t_group               o_group
);
    import bed_pkg::*;

    t_phase              r_phase;
    t_phase              n_phase;
    logic [OVAL_W-1:0]   r_oval;
    logic [OVAL_W-1:0]   n_oval;
    t_group              w_group;
    logic                w_oct;

    function automatic t_group push_byte(t_group g, logic [BYTE_W-1:0] b);
        t_group r;
        r = g;
        if (g.cnt != 2'd3) begin
            r.bytes[g.cnt] = b;
            r.cnt          = g.cnt + 2'd1;
        end
        return r;
    endfunction

    // zero value closes as backslash N
    function automatic t_group finish_octal(t_group g, logic [OVAL_W-1:0] v);
        t_group r;
        r = g;
        if (v == '0) begin
            r = push_byte(r, CH_BACKSLASH);
            r = push_byte(r, CH_UC_N);
        end else begin
            r = push_byte(r, v[BYTE_W-1:0]);
        end
        return r;
    endfunction

    assign w_oct = (i_byte >= CH_ZERO) && (i_byte <= CH_SEVEN);

    always_comb begin
        w_group = '0;
        n_phase = r_phase;
        n_oval  = r_oval;
        unique case (r_phase)
            PH_PLAIN: begin
                if (i_byte == CH_BACKSLASH) begin
                    n_phase = PH_ESC;
                end else begin
                    w_group = push_byte(w_group, i_byte);
                end
            end
            PH_ESC: begin
                if (w_oct) begin
                    n_oval  = {{(OVAL_W-3){1'b0}}, i_byte[2:0]};
                    n_phase = PH_OCT1;
                end else begin
                    n_phase = PH_PLAIN;
                    unique case (i_byte)
                        CH_LC_T: w_group = push_byte(w_group, CH_TAB);
                        CH_LC_S: w_group = push_byte(w_group, CH_BLANK);
                        CH_LC_N: w_group = push_byte(w_group, CH_NEWLINE);
                        CH_LC_R: w_group = push_byte(w_group, CH_CR);
                        CH_LC_B: w_group = push_byte(w_group, CH_BACKSPACE);
                        default: begin
                            w_group = push_byte(w_group, CH_BACKSLASH);
                            w_group = push_byte(w_group, i_byte);
                        end
                    endcase
                end
            end
            PH_OCT1, PH_OCT2: begin
                if (w_oct) begin
                    n_oval = {r_oval[OVAL_W-4:0], i_byte[2:0]};
                    if (r_phase == PH_OCT2) begin
                        w_group = finish_octal(w_group, n_oval);
                        n_oval  = '0;
                        n_phase = PH_PLAIN;
                    end else begin
                        n_phase = PH_OCT2;
                    end
                end else begin
                    // non-digit closes the escape, then is plain text or opens a new escape
                    w_group = finish_octal(w_group, r_oval);
                    n_oval  = '0;
                    n_phase = PH_PLAIN;
                    if (i_byte == CH_BACKSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        w_group = push_byte(w_group, i_byte);
                    end
                end
            end
            default: begin
                n_phase = PH_PLAIN;
                n_oval  = '0;
            end
        endcase

        if (i_last) begin
            if ((n_phase == PH_OCT1) || (n_phase == PH_OCT2)) begin
                w_group = finish_octal(w_group, n_oval);
            end
            n_phase = PH_PLAIN;
            n_oval  = '0;
            // end mark with no byte
            if (w_group.cnt == 2'd0) begin
                w_group.cnt  = 2'd1;
                w_group.bare = 1'b1;
            end
        end
        w_group.arg_last = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_oval  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_oval  <= n_oval;
        end
    end

    assign o_group = w_group;

    `BED_ASSERT_IMP(a_oval_clear_outside_octal, i_clk, i_rst_n,
        (r_phase == PH_PLAIN) || (r_phase == PH_ESC), r_oval == '0)
    `BED_ASSERT_NXT(a_arg_end_resets_phase, i_clk, i_rst_n,
        i_accept && i_last, (r_phase == PH_PLAIN) && (r_oval == '0))

endmodule

`default_nettype wire

// ----- hw/rtl/bed_queue.sv -----
// ---------------------------------------------------------------------------
// bed_queue
// two-group result buffer that serializes each group onto the output
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "backslash_escape_decoder_macros.svh"

module bed_queue (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire bed_pkg::t_group            i_group,
    output logic                            o_ready,
    output logic                            o_tvalid,
    input  wire logic                       i_tready,
    output logic [bed_pkg::BYTE_W-1:0]      o_byte,
    output logic                            o_bare,
    output logic                            o_arg_end,
    output logic                            o_run_last
);
    import bed_pkg::*;

    t_group      r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic [1:0]  r_idx;
    t_group      w_head;
    logic        w_final;
    logic        w_take;
    logic        w_pop;

    assign w_head   = r_mem[r_rd_ptr];
    assign o_tvalid = (r_count != 2'd0);
    assign o_ready  = (r_count != 2'd2);
    assign w_final  = ((r_idx + 2'd1) == w_head.cnt);
    assign w_take   = o_tvalid && i_tready;
    assign w_pop    = w_take && w_final;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_idx    <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_take) begin
                r_idx <= w_final ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    assign o_byte     = w_head.bytes[r_idx];
    assign o_bare     = w_head.bare;
    assign o_arg_end  = w_head.arg_last && w_final;
    assign o_run_last = w_final;

    `BED_ASSERT_IMP(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count != 2'd3)
    `BED_ASSERT_IMP(a_no_push_when_full, i_clk, i_rst_n, i_push, r_count != 2'd2)
    `BED_ASSERT_IMP(a_idx_inside_group, i_clk, i_rst_n, o_tvalid,
        (r_idx < w_head.cnt) && (w_head.cnt != 2'd0))

endmodule

`default_nettype wire
